// File: rtl/etda_pkg.sv
package etda_pkg;

	// Item field widths
	localparam int ECHO_W      = 16;
	localparam int DIG_W       = 4;
	localparam int CNT_W       = 8;
	localparam int OUT_TDATA_W = 32;

	// Kind codes carried on s_tuser
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Fixed-point reciprocals: floor(17*t / 10^k) = (t * RCP) >> SHIFT, exact for 16-bit t.
	// 17/100 is the 170/1000 scale from round-trip microseconds to millimetres.
	localparam int Q_SHIFT = 23;
	localparam int C_SHIFT = 30;
	localparam int B_SHIFT = 33;
	localparam int A_SHIFT = 36;
	localparam logic [20:0] RCP_Q = 21'd1426064;   // 0.17    * 2^23, rounded up
	localparam logic [24:0] RCP_C = 25'd18253612;  // 0.017   * 2^30, rounded up
	localparam logic [23:0] RCP_B = 24'd14602889;  // 0.0017  * 2^33, rounded up
	localparam logic [23:0] RCP_A = 24'd11682312;  // 0.00017 * 2^36, rounded up

	// Distance in mm and its tenths, hundredths and thousandths
	localparam int Q_W = 14;  // up to 11140
	localparam int C_W = 11;  // up to 1114
	localparam int B_W = 7;   // up to 111
	localparam int A_W = 4;   // up to 11

	// Bit positions of the result fields inside m_tdata
	localparam int TENS_LSB = 0;
	localparam int M_LSB    = 4;
	localparam int DM_LSB   = 8;
	localparam int CM_LSB   = 12;
	localparam int MM_LSB   = 16;
	localparam int IVL_LSB  = 20;
	localparam int BEEP_BIT = 24;

endpackage

// File: rtl/echo_time_to_distance_alarm.sv
// Channel  Dir  tdata                       tuser
// s_*      in   [15:0] echo_count           [0] kind (0 echo, 1 tick)
// m_*      out  [3:0] tens_metres, [7:4] metres, [11:8] decimetres,
//               [15:12] centimetres, [19:16] millimetres,
//               [23:20] beep_interval, [24] beeper_level, [31:25] zero
//
// One item per cycle sustained while m_tready stays high; an accepted item moves from the
// input register to the quotient register and then to the result register, which shows
// its one result.
// The four parallel reciprocal multiplies set the stage s1 to s2 path; the state update is
// a few shift-adds and compares in the last stage.
// Reset clears the shown digits, interval and beat counter and sets the beeper high.
// A stalled m_tready holds the result; the two front stages keep filling until full.
module echo_time_to_distance_alarm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [etda_pkg::ECHO_W-1:0]      s_tdata,   // [15:0] echo_count
	input  logic                             s_tuser,   // [0] kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [etda_pkg::OUT_TDATA_W-1:0] m_tdata    // see table above
);
	import etda_pkg::*;

	// Pipeline handshake
	logic valid_s1, valid_s2, out_valid_q;
	logic adv_out;  // result register may load
	logic load_s2;  // quotient register may load

	// Stage 1: captured item
	logic              kind_s1;
	logic [ECHO_W-1:0] echo_s1;

	// Stage 2: distance and its scaled quotients
	logic           kind_s2;
	logic [Q_W-1:0] q_s2;
	logic [C_W-1:0] c_s2;
	logic [B_W-1:0] b_s2;
	logic [A_W-1:0] a_s2;

	// Reciprocal products
	logic [36:0] prod_q;
	logic [40:0] prod_c;
	logic [39:0] prod_b;
	logic [39:0] prod_a;

	// Architectural state; it doubles as the result register
	logic [DIG_W-1:0] tens_q, m_q, dm_q, cm_q, mm_q, ivl_q;
	logic [CNT_W-1:0] cnt_q;
	logic             beep_q;

	// Digit split of the new echo
	logic [Q_W-1:0]   mm_full;
	logic [C_W-1:0]   cm_full;
	logic [B_W-1:0]   dm_full;
	logic [DIG_W-1:0] tens_d, m_d, dm_d, cm_d, mm_d, ivl_d;
	logic             upper_nz;
	logic [CNT_W-1:0] cnt_inc;
	logic             beat_hit;

	assign adv_out  = !out_valid_q || m_tready;
	assign load_s2  = !valid_s2 || adv_out;
	assign s_tready = !valid_s1 || load_s2;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			echo_s1 <= s_tdata;
		end
	end

	// Scale by 17/100, 17/1000, 17/10^4, 17/10^5 in parallel
	assign prod_q = 37'(echo_s1) * 37'(RCP_Q);
	assign prod_c = 41'(echo_s1) * 41'(RCP_C);
	assign prod_b = 40'(echo_s1) * 40'(RCP_B);
	assign prod_a = 40'(echo_s1) * 40'(RCP_A);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			kind_s2 <= kind_s1;
			q_s2    <= prod_q[Q_SHIFT +: Q_W];
			c_s2    <= prod_c[C_SHIFT +: C_W];
			b_s2    <= prod_b[B_SHIFT +: B_W];
			a_s2    <= prod_a[A_SHIFT +: A_W];
		end
	end

	// Each digit is a quotient less ten times the next coarser one
	assign mm_full = q_s2 - {c_s2, 3'b000} - Q_W'({c_s2, 1'b0});
	assign cm_full = c_s2 - C_W'({b_s2, 3'b000}) - C_W'({b_s2, 1'b0});
	assign dm_full = b_s2 - {a_s2, 3'b000} - B_W'({a_s2, 1'b0});
	assign mm_d    = mm_full[DIG_W-1:0];
	assign cm_d    = cm_full[DIG_W-1:0];
	assign dm_d    = dm_full[DIG_W-1:0];
	// Metres total never exceeds 11, so one compare splits off the tens digit
	assign tens_d  = (a_s2 >= 4'd10) ? 4'd1 : 4'd0;
	assign m_d     = (a_s2 >= 4'd10) ? (a_s2 - 4'd10) : a_s2;
	assign upper_nz = (tens_d != '0) || (m_d != '0) || (dm_d != '0) || (cm_d != '0);

	// Beep interval: silent when the metres digit is set, else decimetres, else one for centimetres; tens play no part
	always_comb begin
		priority if (m_d != '0) begin
			ivl_d = '0;
		end else if (dm_d != '0) begin
			ivl_d = dm_d;
		end else if (cm_d != '0) begin
			ivl_d = 4'd1;
		end else begin
			ivl_d = '0;
		end
	end

	assign cnt_inc  = cnt_q + 8'd1;
	assign beat_hit = cnt_inc >= {4'd0, ivl_q};

	// Apply the item to the state as it moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tens_q <= '0;
			m_q    <= '0;
			dm_q   <= '0;
			cm_q   <= '0;
			mm_q   <= '0;
			ivl_q  <= '0;
			cnt_q  <= '0;
			beep_q <= 1'b1;
		end else if (adv_out && valid_s2) begin
			if (kind_s2 == KIND_ECHO) begin
				// Drop echoes below a centimetre: hold the shown digits
				if (upper_nz) begin
					tens_q <= tens_d;
					m_q    <= m_d;
					dm_q   <= dm_d;
					cm_q   <= cm_d;
					mm_q   <= mm_d;
					ivl_q  <= ivl_d;
				end
			end else begin
				if (ivl_q != '0) begin
					if (beat_hit) begin
						cnt_q  <= '0;
						beep_q <= !beep_q;
					end else begin
						cnt_q <= cnt_inc;
					end
				end else begin
					// No alarm: hold the line high, keep the counter running
					cnt_q  <= cnt_inc;
					beep_q <= 1'b1;
				end
			end
		end
	end

	assign m_tdata = {7'd0, beep_q, ivl_q, mm_q, cm_q, dm_q, m_q, tens_q};

endmodule

// File: rtl/etda_checker.sv
module etda_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [etda_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import etda_pkg::*;

	logic [DIG_W-1:0] tens, met, dm, cm, ivl;
	logic             beep, upper_nz;

	assign tens     = m_tdata[TENS_LSB +: DIG_W];
	assign met      = m_tdata[M_LSB +: DIG_W];
	assign dm       = m_tdata[DM_LSB +: DIG_W];
	assign cm       = m_tdata[CM_LSB +: DIG_W];
	assign ivl      = m_tdata[IVL_LSB +: DIG_W];
	assign beep     = m_tdata[BEEP_BIT];
	assign upper_nz = (tens != '0) || (met != '0) || (dm != '0) || (cm != '0);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Once a distance is shown, it is never replaced by a blank reading
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && upper_nz |=> upper_nz)
		else $error("shown distance went back to zero");

	// Interval always follows the shown digits
	a_ivl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((met != '0 && ivl == '0) ||
		              (met == '0 && dm != '0 && ivl == dm) ||
		              (met == '0 && dm == '0 && cm != '0 && ivl == 4'd1) ||
		              (met == '0 && dm == '0 && cm == '0 && ivl == '0)))
		else $error("beep interval does not match digits");

	// The beeper only drops low while an alarm interval is active
	a_beep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(beep) |-> ivl != '0)
		else $error("beeper toggled low without an interval");

endmodule

bind echo_time_to_distance_alarm etda_checker u_etda_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import etda_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 9;
	localparam int MAX_WAIT = 8;           // longest idle draw on either side
	localparam int IDLE_LIMIT = 2000;      // cycles with no handshake before giving up
	localparam int REPORT_LIMIT = 10;      // mismatches printed in full
	localparam int SETTLE_CYCLES = 8;      // pipeline runs through input, quotient and result registers

	// One display reading, as carried on m_tdata
	typedef struct packed {
		logic [DIG_W-1:0] tens;
		logic [DIG_W-1:0] m;
		logic [DIG_W-1:0] dm;
		logic [DIG_W-1:0] cm;
		logic [DIG_W-1:0] mm;
		logic [DIG_W-1:0] ivl;
		logic             beep;
	} reading_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [ECHO_W-1:0]      s_tdata = '0;      // [15:0] echo_count
	logic                   s_tuser = KIND_ECHO; // [0] kind
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;           // [3:0] tens .. [23:20] interval, [24] beeper

	// Predicted block state
	logic [DIG_W-1:0] disp_digits [5];  // 0 = millimetres .. 4 = tens of metres
	logic [DIG_W-1:0] alarm_interval;
	logic [CNT_W-1:0] beat_count;
	logic             beep_level;

	reading_t    expected_readings [$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	logic        burst_mode = 1'b0;  // no idling on either side while set

	echo_time_to_distance_alarm u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Advance the predicted state by one item and return the reading it shows
	function automatic reading_t predict_reading(input logic kind, input logic [ECHO_W-1:0] echo);
		int unsigned travel;
		logic [DIG_W-1:0] dig [5];
		reading_t r;
		if (kind == KIND_ECHO) begin
			// round-trip microseconds times 170 gives micrometres
			travel = echo * 32'd170;
			dig[4] = DIG_W'(travel / 32'd10000000);
			travel = travel % 32'd10000000;
			dig[3] = DIG_W'(travel / 32'd1000000);
			travel = travel % 32'd1000000;
			dig[2] = DIG_W'(travel / 32'd100000);
			travel = travel % 32'd100000;
			dig[1] = DIG_W'(travel / 32'd10000);
			travel = travel % 32'd10000;
			dig[0] = DIG_W'(travel / 32'd1000);
			// too close to show anything: keep the old reading
			if ((dig[4] | dig[3] | dig[2] | dig[1]) != '0) begin
				disp_digits = dig;
				// tens of metres plays no part in the alarm rate
				if (dig[3] != '0)
					alarm_interval = '0;
				else if (dig[2] != '0)
					alarm_interval = dig[2];
				else if (dig[1] != '0)
					alarm_interval = 4'd1;
				else
					alarm_interval = '0;
			end
		end else begin
			beat_count = beat_count + 1'b1;
			if (alarm_interval != '0) begin
				if (beat_count >= CNT_W'(alarm_interval)) begin
					beat_count = '0;
					beep_level = ~beep_level;
				end
			end else begin
				// no alarm: hold the line high, let the counter run and wrap
				beep_level = 1'b1;
			end
		end
		r.tens = disp_digits[4];
		r.m    = disp_digits[3];
		r.dm   = disp_digits[2];
		r.cm   = disp_digits[1];
		r.mm   = disp_digits[0];
		r.ivl  = alarm_interval;
		r.beep = beep_level;
		return r;
	endfunction

	// Offer one item after a random gap; called and left at a falling edge
	task automatic send_item(input logic kind, input logic [ECHO_W-1:0] echo);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = echo;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_readings.push_back(predict_reading(kind, echo));
		@(negedge clk);
	endtask

	// Tick items carry junk in tdata; the block must ignore it
	task automatic send_tick();
		send_item(KIND_TICK, ECHO_W'($urandom_range(0, 65535)));
	endtask

	// Hold the sender until every pending reading has come back
	task automatic wait_for_drain();
		s_tvalid = 1'b0;
		while (expected_readings.size() != 0) @(negedge clk);
	endtask

	// Pick an echo time from one of the display bands, or anywhere
	function automatic logic [ECHO_W-1:0] draw_echo();
		case ($urandom_range(0, 4))
			0: return ECHO_W'($urandom_range(0, 58));        // below one centimetre
			1: return ECHO_W'($urandom_range(59, 588));      // centimetres only
			2: return ECHO_W'($urandom_range(589, 5882));    // decimetres
			3: return ECHO_W'($urandom_range(5883, 65535));  // metres and up
			default: return ECHO_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Echoes too short to reach the centimetre digit leave the reading alone
	task automatic test_short_echo();
		send_item(KIND_ECHO, 16'd0);
		send_item(KIND_ECHO, 16'd58);
		send_tick();
	endtask

	// Walk the interval choice across each band and the top of the range
	task automatic test_interval_choice();
		send_item(KIND_ECHO, 16'd59);     // centimetres only -> 1
		send_item(KIND_ECHO, 16'd600);    // one decimetre
		send_item(KIND_ECHO, 16'd5000);   // eight decimetres
		send_item(KIND_ECHO, 16'd5882);   // 0.999 m, largest interval
		send_item(KIND_ECHO, 16'd6000);   // metres present -> no alarm
		send_item(KIND_ECHO, 16'd65535);  // longest echo, tens digit set
		send_item(KIND_ECHO, 16'd58824);  // tens only, nothing below
		send_item(KIND_ECHO, 16'd61765);  // tens plus decimetres
		send_item(KIND_ECHO, 16'd59118);  // tens plus centimetres
		send_item(KIND_ECHO, 16'h5555);
		send_item(KIND_ECHO, 16'hAAAA);
	endtask

	// Toggle with a short interval, keep it over an ignored echo, then force high
	task automatic test_beeper_toggle();
		send_item(KIND_ECHO, 16'd1200);   // interval 2
		repeat (5) send_tick();
		send_item(KIND_ECHO, 16'd20);
		repeat (2) send_tick();
		send_item(KIND_ECHO, 16'd6000);
		repeat (2) send_tick();
	endtask

	// Run the counter past 255 with no alarm, then arm the slowest interval
	task automatic test_counter_wrap();
		int unsigned run_len;
		repeat (2) begin
			send_item(KIND_ECHO, 16'd6000);
			run_len = $urandom_range(250, 265);
			repeat (run_len) send_tick();
			send_item(KIND_ECHO, 16'd5882);
			repeat (20) send_tick();
		end
	endtask

	// Mostly short tick runs between echoes from all bands
	task automatic test_random_mix(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		sent = 0;
		while (sent < n_items) begin
			send_item(KIND_ECHO, draw_echo());
			run_len = $urandom_range(0, 12);
			repeat (run_len) send_tick();
			sent += run_len + 1;
		end
	endtask

	// Same mix with both sides always ready
	task automatic test_back_to_back(input int unsigned n_items);
		burst_mode = 1'b1;
		test_random_mix(n_items);
		burst_mode = 1'b0;
	endtask

	// Receiver: stall a random number of cycles before each reading
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Compare each reading with the oldest prediction
	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tens = m_tdata[TENS_LSB +: DIG_W];
			got.m    = m_tdata[M_LSB +: DIG_W];
			got.dm   = m_tdata[DM_LSB +: DIG_W];
			got.cm   = m_tdata[CM_LSB +: DIG_W];
			got.mm   = m_tdata[MM_LSB +: DIG_W];
			got.ivl  = m_tdata[IVL_LSB +: DIG_W];
			got.beep = m_tdata[BEEP_BIT];
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected reading %h at %0t", m_tdata, $realtime);
			end else begin
				want = expected_readings.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"reading mismatch at %0t: expected tens %0d m %0d dm %0d ",
							"cm %0d mm %0d ivl %0d beep %0d, got tens %0d m %0d dm %0d ",
							"cm %0d mm %0d ivl %0d beep %0d"}, $realtime,
							want.tens, want.m, want.dm, want.cm, want.mm, want.ivl, want.beep,
							got.tens, got.m, got.dm, got.cm, got.mm, got.ivl, got.beep);
				end
			end
		end
	end

	// Watchdog: give up when no item moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		// reset values of the predicted state
		foreach (disp_digits[i])
			disp_digits[i] = '0;
		alarm_interval = '0;
		beat_count     = '0;
		beep_level     = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_short_echo();
		test_interval_choice();
		test_beeper_toggle();
		wait_for_drain();
		test_counter_wrap();
		test_random_mix(750);
		wait_for_drain();
		test_back_to_back(220);

		// drain, then let the pipeline settle
		s_tvalid = 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
